/* hdl/pfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and types of the partition fit allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Table geometry
    localparam int MAX_PARTITIONS = 128;
    localparam int SIZE_BITS      = 32;
    localparam int IDX_W          = $clog2(MAX_PARTITIONS);
    localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);
    localparam int TOTAL_W        = 39;

    // Field widths fixed by the interface
    localparam int CMD_W     = 3;
    localparam int PIDX_W    = 7;
    localparam int SIZEF_W   = 32;
    localparam int MODE_W    = 2;
    localparam int PCOUNT_W  = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Register map: register index is paddr[2]
    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_PART_COUNT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 3'd0,
        CMD_RESTORE = 3'd1,
        CMD_ALLOC   = 3'd2,
        CMD_CHECK   = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage : pfa_pkg
`default_nettype wire

/* hdl/pfa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : pfa_ram
`default_nettype wire

/* hdl/partition_fit_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// partition_fit_allocator
// Partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// One item is handled at a time. Every command recomputes the free total by
// scanning the partitions in use (n = min(partition_count, 128)) through the
// read port of the remaining-size memory, or of the loaded-size memory for
// restore, one entry per cycle. An item passes a setup step for the load
// write or read lookup, a scan that issues one read per entry, takes in the
// last read and closes, and a finishing step that waits until the output
// register is free. The next item can be taken as soon as the result is
// raised. Allocate picks its partition and restore copies the loaded sizes
// during the same scan. The result sits in an output register, and the
// block can work on the next item while it waits. Entries never loaded
// read as undefined.
// ----------------------------------------------------------------------------
module partition_fit_allocator (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input items
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic [pfa_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [pfa_pkg::PIDX_W-1:0]       s_part_index,
    input  wire logic [pfa_pkg::SIZEF_W-1:0]      s_size_value,
    // result items
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic                             m_granted,
    output      logic [pfa_pkg::PIDX_W-1:0]       m_chosen_index,
    output      logic [pfa_pkg::SIZEF_W-1:0]      m_chosen_remaining,
    output      logic [pfa_pkg::TOTAL_W-1:0]      m_total_free,
    output      logic                             m_frag_flag,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pfa_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [pfa_pkg::PDATA_W-1:0]      pwdata,
    output      logic [pfa_pkg::PDATA_W-1:0]      prdata,
    output      logic                             pready
);

    localparam int IDX_W   = pfa_pkg::IDX_W;
    localparam int CNT_W   = pfa_pkg::CNT_W;
    localparam int SZ_W    = pfa_pkg::SIZE_BITS;
    localparam int TOT_W   = pfa_pkg::TOTAL_W;

    // Configuration registers
    logic [pfa_pkg::MODE_W-1:0]   fit_mode_reg;
    logic [pfa_pkg::PCOUNT_W-1:0] part_count_reg;

    // Control state
    pfa_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            prep_rd_reg, prep_rd_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;

    // Item and scan payload
    pfa_pkg::cmd_t             cmd_reg, cmd_next;
    logic [pfa_pkg::PIDX_W-1:0] idx_reg, idx_next;
    logic [SZ_W-1:0]           req_reg, req_next;
    logic [CNT_W-1:0]          lim_reg, lim_next;
    logic [IDX_W-1:0]          rd_tag_reg, rd_tag_next;
    logic [TOT_W-1:0]          sum_reg, sum_next;
    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          pick_idx_reg, pick_idx_next;
    logic [SZ_W-1:0]           pick_val_reg, pick_val_next;
    logic [SZ_W-1:0]           rd_rem_reg, rd_rem_next;

    // Output payload
    logic                        o_granted_reg, o_granted_next;
    logic [pfa_pkg::PIDX_W-1:0]  o_index_reg, o_index_next;
    logic [pfa_pkg::SIZEF_W-1:0] o_rem_reg, o_rem_next;
    logic [TOT_W-1:0]            o_total_reg, o_total_next;
    logic                        o_frag_reg, o_frag_next;

    // Memory ports
    logic             load_we, rem_we;
    logic [IDX_W-1:0] load_waddr, rem_waddr, rem_raddr, scan_addr;
    logic [SZ_W-1:0]  load_wdata, rem_wdata, load_rdata, rem_rdata;

    // Scan helpers
    logic             idx_ok;
    logic [IDX_W-1:0] idx_addr;
    logic [CNT_W-1:0] lim_calc;
    logic [SZ_W-1:0]  scan_val;
    logic             qual, take;
    pfa_pkg::fit_t    eff_mode;
    logic [SZ_W-1:0]  carved;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg   <= '0;
            part_count_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                pfa_pkg::REG_FIT_MODE:   fit_mode_reg   <= pwdata[pfa_pkg::MODE_W-1:0];
                pfa_pkg::REG_PART_COUNT: part_count_reg <= pwdata[pfa_pkg::PCOUNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pfa_pkg::REG_FIT_MODE:
                prdata = pfa_pkg::PDATA_W'(fit_mode_reg);
            pfa_pkg::REG_PART_COUNT:
                prdata = pfa_pkg::PDATA_W'(part_count_reg);
        endcase
    end

    // ------------------------------------------------------------------------
    // Partition memories
    // ------------------------------------------------------------------------
    pfa_ram #(.WIDTH(SZ_W), .DEPTH(pfa_pkg::MAX_PARTITIONS)) u_loaded_ram (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (load_waddr),
        .wdata (load_wdata),
        .raddr (scan_addr),
        .rdata (load_rdata)
    );

    pfa_ram #(.WIDTH(SZ_W), .DEPTH(pfa_pkg::MAX_PARTITIONS)) u_remaining_ram (
        .aclk  (aclk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .raddr (rem_raddr),
        .rdata (rem_rdata)
    );

    // ------------------------------------------------------------------------
    // Address and limit helpers
    // ------------------------------------------------------------------------
    assign idx_ok    = (32'(idx_reg) < 32'(pfa_pkg::MAX_PARTITIONS));
    assign idx_addr  = IDX_W'(idx_reg);
    assign scan_addr = scan_cnt_reg[IDX_W-1:0];
    assign rem_raddr = (state_reg == pfa_pkg::ST_PREP) ? idx_addr : scan_addr;
    assign lim_calc  = (32'(part_count_reg) > 32'(pfa_pkg::MAX_PARTITIONS))
                     ? CNT_W'(pfa_pkg::MAX_PARTITIONS)
                     : CNT_W'(part_count_reg);

    // Scanned value: restore sums the loaded sizes it copies back
    assign scan_val = (cmd_reg == pfa_pkg::CMD_RESTORE) ? load_rdata : rem_rdata;
    assign qual     = (scan_val != '0) && (req_reg <= scan_val);
    assign eff_mode = (cmd_reg == pfa_pkg::CMD_CHECK) ? pfa_pkg::FIT_FIRST
                                                      : pfa_pkg::fit_t'(fit_mode_reg);
    assign carved   = pick_val_reg - req_reg;

    always_comb begin
        unique case (eff_mode)
            pfa_pkg::FIT_FIRST: take = qual && !found_reg;
            pfa_pkg::FIT_BEST:  take = qual && (!found_reg || scan_val < pick_val_reg);
            pfa_pkg::FIT_WORST: take = qual && (!found_reg || scan_val > pick_val_reg);
            default:            take = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state, memory accesses and result
    // ------------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rd_pend_next  = 1'b0;
        prep_rd_next  = 1'b0;
        scan_cnt_next = scan_cnt_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        lim_next      = lim_reg;
        rd_tag_next   = rd_tag_reg;
        sum_next      = sum_reg;
        found_next    = found_reg;
        pick_idx_next = pick_idx_reg;
        pick_val_next = pick_val_reg;
        rd_rem_next   = rd_rem_reg;
        o_granted_next = o_granted_reg;
        o_index_next   = o_index_reg;
        o_rem_next     = o_rem_reg;
        o_total_next   = o_total_reg;
        o_frag_next    = o_frag_reg;
        load_we    = 1'b0;
        load_waddr = idx_addr;
        load_wdata = req_reg;
        rem_we     = 1'b0;
        rem_waddr  = idx_addr;
        rem_wdata  = req_reg;

        unique case (state_reg)
            // Take an item and clear the scan
            pfa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd_next      = pfa_pkg::cmd_t'(s_cmd);
                    idx_next      = s_part_index;
                    req_next      = s_size_value[SZ_W-1:0];
                    lim_next      = lim_calc;
                    scan_cnt_next = '0;
                    sum_next      = '0;
                    found_next    = 1'b0;
                    pick_idx_next = '0;
                    pick_val_next = '0;
                    rd_rem_next   = '0;
                    state_next    = pfa_pkg::ST_PREP;
                end
            end

            // Store a load, or look up the partition to read
            pfa_pkg::ST_PREP: begin
                unique case (cmd_reg)
                    pfa_pkg::CMD_LOAD: begin
                        load_we = idx_ok;
                        rem_we  = idx_ok;
                    end
                    pfa_pkg::CMD_READ: prep_rd_next = idx_ok;
                    default: ;
                endcase
                state_next = pfa_pkg::ST_SCAN;
            end

            // Issue one read a cycle, process the previous one
            pfa_pkg::ST_SCAN: begin
                if (prep_rd_reg) begin
                    rd_rem_next = rem_rdata;
                end
                if (scan_cnt_reg < lim_reg) begin
                    rd_pend_next  = 1'b1;
                    rd_tag_next   = scan_addr;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end else if (!rd_pend_reg) begin
                    state_next = pfa_pkg::ST_FINISH;
                end
                if (rd_pend_reg) begin
                    sum_next = sum_reg + TOT_W'(scan_val);
                    if (cmd_reg == pfa_pkg::CMD_RESTORE) begin
                        rem_we    = 1'b1;
                        rem_waddr = rd_tag_reg;
                        rem_wdata = load_rdata;
                    end
                    if ((cmd_reg == pfa_pkg::CMD_ALLOC || cmd_reg == pfa_pkg::CMD_CHECK)
                        && take) begin
                        found_next    = 1'b1;
                        pick_idx_next = rd_tag_reg;
                        pick_val_next = scan_val;
                    end
                end
            end

            // Carve the grant and hand over the result
            pfa_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    o_granted_next = 1'b0;
                    o_index_next   = '0;
                    o_rem_next     = '0;
                    o_total_next   = sum_reg;
                    o_frag_next    = 1'b0;
                    unique case (cmd_reg)
                        pfa_pkg::CMD_LOAD: begin
                            o_index_next = idx_reg;
                            o_rem_next   = idx_ok ? pfa_pkg::SIZEF_W'(req_reg) : '0;
                        end
                        pfa_pkg::CMD_ALLOC: begin
                            if (found_reg) begin
                                rem_we         = 1'b1;
                                rem_waddr      = pick_idx_reg;
                                rem_wdata      = carved;
                                o_granted_next = 1'b1;
                                o_index_next   = pfa_pkg::PIDX_W'(pick_idx_reg);
                                o_rem_next     = pfa_pkg::SIZEF_W'(carved);
                                o_total_next   = sum_reg - TOT_W'(req_reg);
                            end
                        end
                        pfa_pkg::CMD_CHECK: begin
                            o_frag_next = (TOT_W'(req_reg) <= sum_reg) && !found_reg;
                        end
                        pfa_pkg::CMD_READ: begin
                            o_index_next = idx_reg;
                            o_rem_next   = pfa_pkg::SIZEF_W'(rd_rem_reg);
                        end
                        default: ;
                    endcase
                    m_valid_next = 1'b1;
                    state_next   = pfa_pkg::ST_IDLE;
                end
            end

            default: state_next = pfa_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pfa_pkg::ST_IDLE;
            m_valid_reg  <= 1'b0;
            rd_pend_reg  <= 1'b0;
            prep_rd_reg  <= 1'b0;
            scan_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rd_pend_reg  <= rd_pend_next;
            prep_rd_reg  <= prep_rd_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        req_reg       <= req_next;
        lim_reg       <= lim_next;
        rd_tag_reg    <= rd_tag_next;
        sum_reg       <= sum_next;
        found_reg     <= found_next;
        pick_idx_reg  <= pick_idx_next;
        pick_val_reg  <= pick_val_next;
        rd_rem_reg    <= rd_rem_next;
        o_granted_reg <= o_granted_next;
        o_index_reg   <= o_index_next;
        o_rem_reg     <= o_rem_next;
        o_total_reg   <= o_total_next;
        o_frag_reg    <= o_frag_next;
    end

    // Ports
    assign s_ready            = (state_reg == pfa_pkg::ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_granted          = o_granted_reg;
    assign m_chosen_index     = o_index_reg;
    assign m_chosen_remaining = o_rem_reg;
    assign m_total_free       = o_total_reg;
    assign m_frag_flag        = o_frag_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfa_pkg::ST_SCAN) |-> (scan_cnt_reg <= lim_reg))
        else $error("scan ran past the partitions in use");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == pfa_pkg::ST_FINISH))
        else $error("result raised outside the finishing step");

    a_grant_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && o_granted_reg) |-> !o_frag_reg)
        else $error("grant and fragmentation flag both set");

    a_write_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_we && state_reg == pfa_pkg::ST_FINISH) |=> (state_reg == pfa_pkg::ST_IDLE))
        else $error("grant write-back without leaving the finishing step");

endmodule : partition_fit_allocator
`default_nettype wire
